// ----- rtl/ecs_pkg.sv -----
// ----------------------------------------------------------------------------
// ecs_pkg
// Shared types, widths and codes of the compartment step core.
// ----------------------------------------------------------------------------
package ecs_pkg;

  localparam int COUNT_WIDTH = 48;
  localparam int RATE_WIDTH  = 32;
  localparam int COUNT_FRAC  = 16;
  localparam int RATE_FRAC   = RATE_WIDTH - 2;
  localparam int ALPHA_FRAC  = COUNT_WIDTH;
  localparam int NCOMP       = 10;
  localparam int IDX_WIDTH   = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int ACC_WIDTH   = 64;

  // compartment slots
  localparam logic [IDX_WIDTH-1:0] C_S  = 4'd0;
  localparam logic [IDX_WIDTH-1:0] C_E  = 4'd1;
  localparam logic [IDX_WIDTH-1:0] C_I  = 4'd2;
  localparam logic [IDX_WIDTH-1:0] C_II = 4'd3;
  localparam logic [IDX_WIDTH-1:0] C_RE = 4'd4;
  localparam logic [IDX_WIDTH-1:0] C_RI = 4'd5;
  localparam logic [IDX_WIDTH-1:0] C_SI = 4'd6;
  localparam logic [IDX_WIDTH-1:0] C_RR = 4'd7;
  localparam logic [IDX_WIDTH-1:0] C_D  = 4'd8;
  localparam logic [IDX_WIDTH-1:0] C_V  = 4'd9;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INCUBATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEATH      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMMUNITY   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WANING     = 2'd3;

  // input commands
  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // multiplier operation codes
  localparam int MOP_WIDTH = 4;
  localparam logic [MOP_WIDTH-1:0] MOP_AS   = 4'd0;  // alpha*S
  localparam logic [MOP_WIDTH-1:0] MOP_ASI  = 4'd1;  // alpha*SI
  localparam logic [MOP_WIDTH-1:0] MOP_ASE  = 4'd2;  // (alpha*S)*E
  localparam logic [MOP_WIDTH-1:0] MOP_ASIE = 4'd3;  // (alpha*SI)*E
  localparam logic [MOP_WIDTH-1:0] MOP_PSE  = 4'd4;  // phi*(..)
  localparam logic [MOP_WIDTH-1:0] MOP_RS   = 4'd5;
  localparam logic [MOP_WIDTH-1:0] MOP_RE   = 4'd6;
  localparam logic [MOP_WIDTH-1:0] MOP_RRE  = 4'd7;
  localparam logic [MOP_WIDTH-1:0] MOP_BE   = 4'd8;
  localparam logic [MOP_WIDTH-1:0] MOP_GE   = 4'd9;
  localparam logic [MOP_WIDTH-1:0] MOP_GI   = 4'd10;
  localparam logic [MOP_WIDTH-1:0] MOP_EI   = 4'd11;
  localparam logic [MOP_WIDTH-1:0] MOP_ZRI  = 4'd12;
  localparam logic [MOP_WIDTH-1:0] MOP_WV   = 4'd13;
  localparam int NMOP = 14;

  typedef struct packed {
    logic                   cmd;
    logic [IDX_WIDTH-1:0]   compartment_index;
    logic [COUNT_WIDTH-1:0] load_value;
    logic [COUNT_WIDTH-1:0] infection_rate;
    logic [RATE_WIDTH-1:0]  recovery_rate;
    logic [RATE_WIDTH-1:0]  vaccination_rate;
    logic [RATE_WIDTH-1:0]  reinfection_factor;
  } in_word_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] susceptible;
    logic [COUNT_WIDTH-1:0] exposed;
    logic [COUNT_WIDTH-1:0] infectious;
    logic [COUNT_WIDTH-1:0] reinfected;
    logic [COUNT_WIDTH-1:0] recovered_exposed;
    logic [COUNT_WIDTH-1:0] recovered_infectious;
    logic [COUNT_WIDTH-1:0] resusceptible;
    logic [COUNT_WIDTH-1:0] recovered_reinfected;
    logic [COUNT_WIDTH-1:0] deceased;
    logic [COUNT_WIDTH-1:0] vaccinated;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic                 capture;   // latch input word and rates
    logic                 load;      // write one compartment
    logic                 mul_go;    // start multiply of mop
    logic [MOP_WIDTH-1:0] mop;
    logic                 settle;    // form the new compartments
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mul_done;
  } dp_sts_t;

  // saturating 64-bit add
  function automatic logic [ACC_WIDTH-1:0] sat_add(input logic [ACC_WIDTH-1:0] a,
                                                   input logic [ACC_WIDTH-1:0] b);
    logic [ACC_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : s[ACC_WIDTH-1:0];
  endfunction

  // clamp at zero and at the largest count
  function automatic logic [COUNT_WIDTH-1:0] settle(input logic [ACC_WIDTH-1:0] pos,
                                                    input logic [ACC_WIDTH-1:0] neg);
    logic [ACC_WIDTH-1:0] d;
    d = pos - neg;
    if (neg >= pos) settle = '0;
    else if (d[ACC_WIDTH-1:COUNT_WIDTH] != '0) settle = {COUNT_WIDTH{1'b1}};
    else settle = d[COUNT_WIDTH-1:0];
  endfunction

endpackage

// ----- rtl/ecs_mul.sv -----
// ----------------------------------------------------------------------------
// ecs_mul
// Sequential 64x64 multiplier: one 32x32 partial product per cycle, then a
// floor shift right and saturation to 64 bits.
// ----------------------------------------------------------------------------
module ecs_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  logic [6:0]  sh,
  output logic        done,
  output logic [63:0] result
);

  logic [63:0]  a_q, b_q;
  logic [6:0]   sh_q;
  logic [127:0] acc;
  logic [2:0]   phase;
  logic         busy;
  logic [31:0]  op_a, op_b;
  logic [63:0]  pp;
  logic [127:0] pp_ext;
  logic [127:0] shifted;

  // pick the partial product of this phase
  always_comb begin
    op_a = phase[0] ? a_q[63:32] : a_q[31:0];
    op_b = phase[1] ? b_q[63:32] : b_q[31:0];
  end

  assign pp = op_a * op_b;
  assign pp_ext = {64'd0, pp} << ({5'd0, phase[0]} + {5'd0, phase[1]}) * 32;
  assign shifted = acc >> sh_q;

  // accumulate four partial products, then finish
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      phase <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        phase <= '0;
      end else if (busy) begin
        if (phase == 3'd3) begin
          busy <= 1'b0;
          phase <= 3'd4;
        end else begin
          phase <= phase + 3'd1;
        end
      end else if (phase == 3'd4) begin
        phase <= '0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      a_q <= a;
      b_q <= b;
      sh_q <= sh;
      acc <= '0;
    end else if (busy) begin
      acc <= acc + pp_ext;
    end else if (phase == 3'd4) begin
      result <= (shifted[127:64] != '0) ? {64{1'b1}} : shifted[63:0];
    end
  end

endmodule

// ----- rtl/ecs_datapath.sv -----
// ----------------------------------------------------------------------------
// ecs_datapath
// Compartment store, rate registers, shared multiplier and product file.
// ----------------------------------------------------------------------------
module ecs_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [ecs_pkg::CFG_IDX_W-1:0]         cfg_idx,
  input  logic                                  cfg_sel,
  input  logic [ecs_pkg::RATE_WIDTH-1:0]        cfg_data,
  input  ecs_pkg::in_word_t                     in_word,
  input  ecs_pkg::dp_cmd_t                      cmd,
  output ecs_pkg::dp_sts_t                      sts,
  output ecs_pkg::out_word_t                    out_word
);

  localparam int CW = ecs_pkg::COUNT_WIDTH;
  localparam int RW = ecs_pkg::RATE_WIDTH;
  localparam int AW = ecs_pkg::ACC_WIDTH;

  logic [CW-1:0] comp [ecs_pkg::NCOMP];
  logic [RW-1:0] beta, eta, zeta, wane;
  ecs_pkg::in_word_t w_q;
  logic [AW-1:0] prod [ecs_pkg::NMOP];
  logic [AW-1:0] ma, mb, mres;
  logic [6:0]    msh;
  logic          mdone;
  logic [ecs_pkg::MOP_WIDTH-1:0] mop_q;
  ecs_pkg::out_word_t nw;

  // rate registers
  always_ff @(posedge clk) begin
    if (rst) begin
      beta <= '0;
      eta <= '0;
      zeta <= '0;
      wane <= '0;
    end else if (cfg_we && cfg_sel) begin
      unique case (cfg_idx)
        ecs_pkg::REG_INCUBATION: beta <= cfg_data;
        ecs_pkg::REG_DEATH:      eta <= cfg_data;
        ecs_pkg::REG_IMMUNITY:   zeta <= cfg_data;
        ecs_pkg::REG_WANING:     wane <= cfg_data;
        default: ;
      endcase
    end
  end

  // select multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    msh = 7'(ecs_pkg::RATE_FRAC);
    unique case (cmd.mop)
      ecs_pkg::MOP_AS: begin
        ma = AW'(w_q.infection_rate); mb = AW'(comp[ecs_pkg::C_S]);
        msh = 7'(ecs_pkg::ALPHA_FRAC);
      end
      ecs_pkg::MOP_ASI: begin
        ma = AW'(w_q.infection_rate); mb = AW'(comp[ecs_pkg::C_SI]);
        msh = 7'(ecs_pkg::ALPHA_FRAC);
      end
      ecs_pkg::MOP_ASE: begin
        ma = prod[ecs_pkg::MOP_AS]; mb = AW'(comp[ecs_pkg::C_E]);
        msh = 7'(ecs_pkg::COUNT_FRAC);
      end
      ecs_pkg::MOP_ASIE: begin
        ma = prod[ecs_pkg::MOP_ASI]; mb = AW'(comp[ecs_pkg::C_E]);
        msh = 7'(ecs_pkg::COUNT_FRAC);
      end
      ecs_pkg::MOP_PSE: begin
        ma = AW'(w_q.reinfection_factor); mb = prod[ecs_pkg::MOP_ASIE];
      end
      ecs_pkg::MOP_RS:  begin ma = AW'(w_q.vaccination_rate); mb = AW'(comp[ecs_pkg::C_S]); end
      ecs_pkg::MOP_RE:  begin ma = AW'(w_q.vaccination_rate); mb = AW'(comp[ecs_pkg::C_E]); end
      ecs_pkg::MOP_RRE: begin ma = AW'(w_q.vaccination_rate); mb = AW'(comp[ecs_pkg::C_RE]); end
      ecs_pkg::MOP_BE:  begin ma = AW'(beta); mb = AW'(comp[ecs_pkg::C_E]); end
      ecs_pkg::MOP_GE:  begin ma = AW'(w_q.recovery_rate); mb = AW'(comp[ecs_pkg::C_E]); end
      ecs_pkg::MOP_GI:  begin ma = AW'(w_q.recovery_rate); mb = AW'(comp[ecs_pkg::C_I]); end
      ecs_pkg::MOP_EI:  begin ma = AW'(eta); mb = AW'(comp[ecs_pkg::C_I]); end
      ecs_pkg::MOP_ZRI: begin ma = AW'(zeta); mb = AW'(comp[ecs_pkg::C_RI]); end
      ecs_pkg::MOP_WV:  begin ma = AW'(wane); mb = AW'(comp[ecs_pkg::C_V]); end
      default: ;
    endcase
  end

  ecs_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .go     (cmd.mul_go),
    .a      (ma),
    .b      (mb),
    .sh     (msh),
    .done   (mdone),
    .result (mres)
  );

  assign sts.mul_done = mdone;

  // hold input word; file the finished product
  always_ff @(posedge clk) begin
    if (cmd.capture) w_q <= in_word;
    if (cmd.mul_go) mop_q <= cmd.mop;
    if (mdone) prod[mop_q] <= mres;
  end

  // new compartment values from the product file
  always_comb begin
    logic [AW-1:0] s, e, i, ii, re, ri, si, rr, d, v;
    s = AW'(comp[ecs_pkg::C_S]);   e = AW'(comp[ecs_pkg::C_E]);
    i = AW'(comp[ecs_pkg::C_I]);   ii = AW'(comp[ecs_pkg::C_II]);
    re = AW'(comp[ecs_pkg::C_RE]); ri = AW'(comp[ecs_pkg::C_RI]);
    si = AW'(comp[ecs_pkg::C_SI]); rr = AW'(comp[ecs_pkg::C_RR]);
    d = AW'(comp[ecs_pkg::C_D]);   v = AW'(comp[ecs_pkg::C_V]);
    nw.susceptible = ecs_pkg::settle(s,
      ecs_pkg::sat_add(prod[ecs_pkg::MOP_ASE], prod[ecs_pkg::MOP_RS]));
    nw.exposed = ecs_pkg::settle(ecs_pkg::sat_add(e, prod[ecs_pkg::MOP_ASE]),
      ecs_pkg::sat_add(ecs_pkg::sat_add(prod[ecs_pkg::MOP_BE], prod[ecs_pkg::MOP_GE]),
                       prod[ecs_pkg::MOP_RE]));
    nw.infectious = ecs_pkg::settle(ecs_pkg::sat_add(i, prod[ecs_pkg::MOP_BE]),
      ecs_pkg::sat_add(prod[ecs_pkg::MOP_GI], prod[ecs_pkg::MOP_EI]));
    nw.reinfected = ecs_pkg::settle(ecs_pkg::sat_add(ii, prod[ecs_pkg::MOP_PSE]), ii);
    nw.recovered_exposed = ecs_pkg::settle(ecs_pkg::sat_add(re, prod[ecs_pkg::MOP_GE]),
      prod[ecs_pkg::MOP_RRE]);
    nw.recovered_infectious = ecs_pkg::settle(ecs_pkg::sat_add(ri, prod[ecs_pkg::MOP_GI]),
      prod[ecs_pkg::MOP_ZRI]);
    nw.resusceptible = ecs_pkg::settle(ecs_pkg::sat_add(ecs_pkg::sat_add(si,
      prod[ecs_pkg::MOP_ZRI]), prod[ecs_pkg::MOP_WV]), prod[ecs_pkg::MOP_PSE]);
    nw.recovered_reinfected = ecs_pkg::settle(ecs_pkg::sat_add(rr, ii), '0);
    nw.deceased = ecs_pkg::settle(ecs_pkg::sat_add(d, prod[ecs_pkg::MOP_EI]), '0);
    nw.vaccinated = ecs_pkg::settle(ecs_pkg::sat_add(ecs_pkg::sat_add(ecs_pkg::sat_add(v,
      prod[ecs_pkg::MOP_RS]), prod[ecs_pkg::MOP_RE]), prod[ecs_pkg::MOP_RRE]),
      prod[ecs_pkg::MOP_WV]);
  end

  // compartment store: load one slot, or update all on settle
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ecs_pkg::NCOMP; k++) comp[k] <= '0;
    end else if (cmd.load) begin
      if (w_q.compartment_index < ecs_pkg::IDX_WIDTH'(ecs_pkg::NCOMP))
        comp[w_q.compartment_index] <= w_q.load_value;
    end else if (cmd.settle) begin
      comp[ecs_pkg::C_S]  <= nw.susceptible;
      comp[ecs_pkg::C_E]  <= nw.exposed;
      comp[ecs_pkg::C_I]  <= nw.infectious;
      comp[ecs_pkg::C_II] <= nw.reinfected;
      comp[ecs_pkg::C_RE] <= nw.recovered_exposed;
      comp[ecs_pkg::C_RI] <= nw.recovered_infectious;
      comp[ecs_pkg::C_SI] <= nw.resusceptible;
      comp[ecs_pkg::C_RR] <= nw.recovered_reinfected;
      comp[ecs_pkg::C_D]  <= nw.deceased;
      comp[ecs_pkg::C_V]  <= nw.vaccinated;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.settle) out_word <= nw;
  end

endmodule

// ----- rtl/ecs_ctrl.sv -----
// ----------------------------------------------------------------------------
// ecs_ctrl
// Controller: takes a word; a load writes one slot, a step sequences the
// fourteen products, settles and presents the result word.
// ----------------------------------------------------------------------------
module ecs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_cmd,
  output logic             out_valid,
  input  logic             out_stall,
  output ecs_pkg::dp_cmd_t cmd,
  input  ecs_pkg::dp_sts_t sts
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_ISSUE  = 3'd2;
  localparam logic [2:0] ST_WAIT   = 3'd3;
  localparam logic [2:0] ST_SETTLE = 3'd4;

  logic [2:0] state, state_next;
  logic [ecs_pkg::MOP_WIDTH-1:0] mop, mop_next;
  logic is_load, is_load_next;
  logic out_valid_next;
  logic accept;

  // accept when idle and no result is waiting
  assign in_stall = (state != ST_IDLE) || out_valid;
  assign accept = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    mop_next = mop;
    is_load_next = is_load;
    out_valid_next = out_valid && out_stall;
    cmd = '0;
    cmd.mop = mop;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          is_load_next = (in_cmd == ecs_pkg::CMD_LOAD);
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (is_load) begin
          cmd.load = 1'b1;
          state_next = ST_IDLE;
        end else begin
          mop_next = ecs_pkg::MOP_AS;
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd.mul_go = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts.mul_done) begin
          if (mop == ecs_pkg::MOP_WIDTH'(ecs_pkg::NMOP - 1)) begin
            state_next = ST_SETTLE;
          end else begin
            mop_next = mop + 1'b1;
            state_next = ST_ISSUE;
          end
        end
      end
      ST_SETTLE: begin
        cmd.settle = 1'b1;
        out_valid_next = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mop <= '0;
      is_load <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      mop <= mop_next;
      is_load <= is_load_next;
      out_valid <= out_valid_next;
    end
  end

  // a stalled result stays up
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");
  // no word is taken while a step is in flight
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> in_stall)
    else $error("input open while busy");
  // settle only after the last product
  a_settle: assert property (@(posedge clk) disable iff (rst)
    state == ST_SETTLE |-> mop == ecs_pkg::MOP_WIDTH'(ecs_pkg::NMOP - 1))
    else $error("settle before products done");

endmodule

// ----- rtl/epidemic_compartment_step_core.sv -----
// ----------------------------------------------------------------------------
// epidemic_compartment_step_core
// Ten-compartment epidemic model, one time step per step word.
// ----------------------------------------------------------------------------
// channel  | signals                          | word
// in       | in_valid, in_stall, in_data      | load or step command
// out      | out_valid, out_stall, out_data   | ten new compartments
// cfg      | cfg_we, cfg_idx, cfg_data        | four rate registers
//
// A load is accepted in the idle state, then the decode state writes the slot.
// A step runs from accept through decode, then issue and wait for each of the
// fourteen products on the one shared 64x64 multiplier (four 32x32 partial
// products, shift and saturate, hand back), and ends in settle.
// Reset clears compartments, rates and control synchronously.
// The input stalls while a word is in work or a result waits to be taken.
// ----------------------------------------------------------------------------
module epidemic_compartment_step_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ecs_pkg::in_word_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ecs_pkg::out_word_t              out_data,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_idx,
  input  logic [ecs_pkg::RATE_WIDTH-1:0]  cfg_data
);

  ecs_pkg::dp_cmd_t cmd;
  ecs_pkg::dp_sts_t sts;

  ecs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_data.cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  ecs_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_sel  (1'b1),
    .cfg_data (cfg_data),
    .in_word  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_word (out_data)
  );

endmodule
